// ===== design/rle565_pkg.sv =====
// shared types, constants and the rgb565 packing function for the run-length encoder
// no dependencies; imported by rle565_ofifo and rgb565_run_length_encoder
package rle565_pkg;

	localparam logic [15:0] RUN_MAX       = 16'hFFFF;
	localparam int          RLE_OUT_DEPTH = 4;
	localparam int          CFG_ADDR_W    = 2;

	// configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] CFG_RLE_ENABLE = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_GREY_MODE  = 2'd1;

	typedef struct packed {
		logic        end_of_image;
		logic [15:0] colour565;
		logic [15:0] run_count;
	} result_t;

	typedef struct packed {
		logic push0;
		logic push1;
	} push_t;

	function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

endpackage

// ===== design/rle565_ofifo.sv =====
// result queue of the run-length encoder: takes up to two results a cycle, hands out one
// depends on rle565_pkg (result_t, push_t, RLE_OUT_DEPTH)
module rle565_ofifo
	import rle565_pkg::*;
#(
	parameter int Depth = RLE_OUT_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  push_t   push,
	input  result_t din0,
	input  result_t din1,
	output logic    room2,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t dout
);

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	result_t         mem_q [Depth];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic [AW-1:0]   wr_ptr_nx1;
	logic            pop;
	logic [CW-1:0]   n_push;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(Depth - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr_ptr_nx1 = ptr_inc(wr_ptr_q);
	assign pop        = out_valid & out_ready;
	assign n_push     = CW'(push.push0) + CW'(push.push1);
	assign out_valid  = (count_q != '0);
	assign dout       = mem_q[rd_ptr_q];
	assign room2      = (count_q <= CW'(Depth - 2));

	always_ff @(posedge clk) begin
		if (push.push0) begin
			mem_q[wr_ptr_q] <= din0;
		end
		if (push.push1) begin
			mem_q[wr_ptr_nx1] <= din1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.push1) begin
				wr_ptr_q <= ptr_inc(wr_ptr_nx1);
			end else if (push.push0) begin
				wr_ptr_q <= wr_ptr_nx1;
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			count_q <= count_q + n_push - CW'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(Depth))
		else $error("result queue count above depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.push0 || push.push1) |-> room2)
		else $error("result queue written without room for two");

	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.push1 |-> push.push0)
		else $error("second result slot written without the first");

endmodule

// ===== design/rgb565_run_length_encoder.sv =====
// channel     | signals                          | contents
// ------------+----------------------------------+----------------------------------------
// pixel in    | s_tvalid s_tready s_tdata s_tlast | red, green, blue bytes; tlast = last pixel
// result out  | m_tvalid m_tready m_tdata m_tlast | run_count, colour565; tlast = end of image
// config      | cfg_wr_en cfg_addr cfg_wdata      | 0 rle_enable, 1 grey_mode
//
// one pixel per cycle while the result queue has room for two results.
// a pixel that closes a run and ends the image gives two results, written to the result
// queue in one cycle and drained one per cycle, so the output port sets the rate then.
// a pixel waits in the input register until the queue has room for two results.
// reset clears the configuration, the open run and the queue.
module rgb565_run_length_encoder
	import rle565_pkg::*;
#(
	parameter int OutDepth = RLE_OUT_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [23:0]           s_tdata,   // red [7:0], green [15:8], blue [23:16]
	input  logic                  s_tlast,   // last_pixel
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [31:0]           m_tdata,   // run_count [15:0], colour565 [31:16]
	output logic                  m_tlast,   // end_of_image
	input  logic                  cfg_wr_en,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic                  cfg_wdata
);

	logic        rle_en_q;
	logic        grey_q;
	logic        valid_s1;
	logic [7:0]  red_s1;
	logic [7:0]  green_s1;
	logic [7:0]  blue_s1;
	logic        last_s1;
	logic [15:0] run_colour_q;
	logic [15:0] run_len_q;

	logic        room2;
	logic        fire;
	logic [15:0] colour;
	logic        extend;
	logic        flush;
	logic [15:0] len_nx;
	logic [15:0] colour_nx;
	logic        emit2;
	result_t     res_flush;
	result_t     res_main;
	push_t       push;
	result_t     dout;

	assign fire     = valid_s1 & room2;
	assign s_tready = ~valid_s1 | fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rle_en_q <= 1'b0;
			grey_q   <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				CFG_RLE_ENABLE: rle_en_q <= cfg_wdata;
				CFG_GREY_MODE:  grey_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			red_s1   <= s_tdata[7:0];
			green_s1 <= s_tdata[15:8];
			blue_s1  <= s_tdata[23:16];
			last_s1  <= s_tlast;
		end
	end

	always_comb begin
		colour    = grey_q ? pack565(red_s1, red_s1, red_s1)
		                   : pack565(red_s1, green_s1, blue_s1);
		extend    = rle_en_q && (run_len_q != '0) && (colour == run_colour_q)
		            && (run_len_q != RUN_MAX);
		// any open run closes unless this pixel extends it
		flush     = (run_len_q != '0) && !extend;
		colour_nx = extend ? run_colour_q : colour;
		len_nx    = extend ? run_len_q + 16'd1 : 16'd1;
		emit2     = !rle_en_q || last_s1;

		res_flush.run_count    = run_len_q;
		res_flush.colour565    = run_colour_q;
		res_flush.end_of_image = 1'b0;

		res_main.run_count     = rle_en_q ? len_nx : 16'd1;
		res_main.colour565     = colour_nx;
		res_main.end_of_image  = last_s1;

		push.push0 = fire && (flush || emit2);
		push.push1 = fire && flush && emit2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_colour_q <= '0;
			run_len_q    <= '0;
		end else if (fire) begin
			run_colour_q <= colour_nx;
			run_len_q    <= (emit2) ? 16'd0 : len_nx;
		end
	end

	rle565_ofifo #(
		.Depth(OutDepth)
	) u_ofifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.din0     (flush ? res_flush : res_main),
		.din1     (res_main),
		.room2    (room2),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.dout     (dout)
	);

	assign m_tdata = {dout.colour565, dout.run_count};
	assign m_tlast = dout.end_of_image;

	a_plain_no_run: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !rle_en_q) |=> (run_len_q == '0))
		else $error("open run left behind in plain mode");

	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && last_s1) |=> (run_len_q == '0))
		else $error("open run left behind after last pixel");

	a_run_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && extend && !emit2) |=> (run_len_q == $past(run_len_q) + 16'd1))
		else $error("run length did not advance on a repeated colour");

	a_flush_push: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && run_len_q != '0 && !extend) |-> push.push0)
		else $error("closed run was not queued");

endmodule
